/* design/bss_pkg.sv */
// Shared types, codes and defaults for the bounded sequence store.
// No dependencies; imported by every module of the block.
package bss_pkg;

	localparam int BSS_DEPTH = 64;   // default entry count of the store
	localparam int DATA_W    = 32;

	// Request kinds
	localparam logic [2:0] ACT_APPEND   = 3'd0;
	localparam logic [2:0] ACT_PREPEND  = 3'd1;
	localparam logic [2:0] ACT_INSERT   = 3'd2;
	localparam logic [2:0] ACT_SEARCH   = 3'd3;
	localparam logic [2:0] ACT_RM_FRONT = 3'd4;
	localparam logic [2:0] ACT_RM_BACK  = 3'd5;

	// Result status
	localparam logic [2:0] ST_OK       = 3'd0;
	localparam logic [2:0] ST_BADPOS   = 3'd1;
	localparam logic [2:0] ST_EMPTY    = 3'd2;
	localparam logic [2:0] ST_FULL     = 3'd3;
	localparam logic [2:0] ST_NOTFOUND = 3'd4;

	typedef struct packed {
		logic signed [DATA_W-1:0] value;
		logic [6:0]               position;
		logic [2:0]               action;
	} req_t;

	typedef struct packed {
		logic [6:0]               entry_count;
		logic [5:0]               found_position;
		logic signed [DATA_W-1:0] removed_value;
		logic [2:0]               status;
	} res_t;

endpackage

/* design/bounded_sequence_store_unit.sv */
// Top level of the bounded sequence store: stream ports, result register.
// Depends on bss_pkg, bss_ctrl and bss_mem.
//
// Keeps an ordered list of up to DEPTH signed 32-bit values in one
// single-port-read memory. Each request on the slave stream does one
// operation (append, prepend, insert at position, search, remove front,
// remove back) and yields exactly one result on the master stream with a
// status, the removed value, the found position and the entry count after
// the request. Failures (bad position, empty, full, not found) change
// nothing. The memory is walked one entry per cycle with registered read
// data: append, an insert or prepend at the count, errors and unused codes
// need no walk, remove back reads only the last entry, insert at p below
// the count shifts entries p to count - 1 up by one and then fills the gap,
// remove front shifts the rest down, and search stops at the first match.
// A new request is taken while the previous result still waits in the
// output register. No clearing pass is needed after reset: entries are
// only read below the count.
module bounded_sequence_store_unit import bss_pkg::*; #(
	parameter int DEPTH = BSS_DEPTH
) (
	input  logic        clk,
	input  logic        arst_n,
	input  logic        s_tvalid,
	output logic        s_tready,
	input  logic [47:0] s_tdata,   // action[2:0], position[9:3], value[41:10]
	output logic        m_tvalid,
	input  logic        m_tready,
	output logic [47:0] m_tdata    // status[2:0], removed_value[34:3],
	                               // found_position[40:35], entry_count[47:41]
);

	localparam int AW = (DEPTH > 1) ? $clog2(DEPTH) : 1;

	req_t              req;
	res_t              res;
	res_t              out_q;
	logic              out_vld_q;
	logic              res_valid;
	logic              res_ready;

	logic              mem_we;
	logic [AW-1:0]     mem_waddr;
	logic [DATA_W-1:0] mem_wdata;
	logic              mem_re;
	logic [AW-1:0]     mem_raddr;
	logic [DATA_W-1:0] mem_rdata;

	// unpack request
	assign req.action   = s_tdata[2:0];
	assign req.position = s_tdata[9:3];
	assign req.value    = s_tdata[41:10];

	bss_ctrl #(
		.DEPTH(DEPTH)
	) u_ctrl (
		.clk      (clk),
		.arst_n   (arst_n),
		.req_valid(s_tvalid),
		.req_ready(s_tready),
		.req      (req),
		.res_valid(res_valid),
		.res_ready(res_ready),
		.res      (res),
		.mem_we   (mem_we),
		.mem_waddr(mem_waddr),
		.mem_wdata(mem_wdata),
		.mem_re   (mem_re),
		.mem_raddr(mem_raddr),
		.mem_rdata(mem_rdata)
	);

	bss_mem #(
		.DEPTH(DEPTH)
	) u_mem (
		.clk  (clk),
		.we   (mem_we),
		.waddr(mem_waddr),
		.wdata(mem_wdata),
		.re   (mem_re),
		.raddr(mem_raddr),
		.rdata(mem_rdata)
	);

	// result register: loads when empty or being drained this cycle
	assign res_ready = !out_vld_q || m_tready;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			out_vld_q <= 1'b0;
		end else if (res_ready) begin
			out_vld_q <= res_valid;
		end
	end

	always_ff @(posedge clk) begin
		if (res_ready && res_valid) begin
			out_q <= res;
		end
	end

	assign m_tvalid = out_vld_q;
	assign m_tdata  = {out_q.entry_count, out_q.found_position,
	                   out_q.removed_value, out_q.status};

endmodule

/* design/bss_mem.sv */
// Entry memory of the bounded sequence store: one write port, one read port,
// registered read data. Depends on bss_pkg.
module bss_mem import bss_pkg::*; #(
	parameter int DEPTH = BSS_DEPTH
) (
	input  logic                                     clk,
	input  logic                                     we,
	input  logic [((DEPTH > 1) ? $clog2(DEPTH) : 1)-1:0] waddr,
	input  logic [DATA_W-1:0]                        wdata,
	input  logic                                     re,
	input  logic [((DEPTH > 1) ? $clog2(DEPTH) : 1)-1:0] raddr,
	output logic [DATA_W-1:0]                        rdata
);

	logic [DATA_W-1:0] mem [DEPTH];

	always_ff @(posedge clk) begin
		if (we) begin
			mem[waddr] <= wdata;
		end
	end

	always_ff @(posedge clk) begin
		if (re) begin
			rdata <= mem[raddr];
		end
	end

endmodule

/* design/bss_ctrl.sv */
// Request sequencer: decodes a request, walks the entry memory one entry
// per cycle (shift up, shift down, search) and builds the result.
// Depends on bss_pkg; drives the ports of bss_mem.
module bss_ctrl import bss_pkg::*; #(
	parameter int DEPTH = BSS_DEPTH
) (
	input  logic                                     clk,
	input  logic                                     arst_n,
	input  logic                                     req_valid,
	output logic                                     req_ready,
	input  req_t                                     req,
	output logic                                     res_valid,
	input  logic                                     res_ready,
	output res_t                                     res,
	output logic                                     mem_we,
	output logic [((DEPTH > 1) ? $clog2(DEPTH) : 1)-1:0] mem_waddr,
	output logic [DATA_W-1:0]                        mem_wdata,
	output logic                                     mem_re,
	output logic [((DEPTH > 1) ? $clog2(DEPTH) : 1)-1:0] mem_raddr,
	input  logic [DATA_W-1:0]                        mem_rdata
);

	localparam int AW   = (DEPTH > 1) ? $clog2(DEPTH) : 1;
	localparam int CW   = $clog2(DEPTH + 1);
	localparam int CMPW = (CW > 7) ? CW : 7;
	localparam int FW   = (AW > 6) ? AW : 6;

	localparam logic [2:0] S_IDLE = 3'd0;
	localparam logic [2:0] S_INS  = 3'd1;   // shift tail up by one
	localparam logic [2:0] S_FILL = 3'd2;   // write new value into the gap
	localparam logic [2:0] S_SRCH = 3'd3;
	localparam logic [2:0] S_RMF  = 3'd4;   // take front, shift rest down
	localparam logic [2:0] S_RMB  = 3'd5;
	localparam logic [2:0] S_DONE = 3'd6;

	logic [2:0]        state_q, state_d;
	logic [CW-1:0]     cnt_q, cnt_d;
	logic [AW-1:0]     idx_q, idx_d;
	logic [AW-1:0]     pos_q, pos_d;
	logic [DATA_W-1:0] val_q, val_d;
	logic [2:0]        status_q, status_d;
	logic [DATA_W-1:0] removed_q, removed_d;
	logic [5:0]        found_q, found_d;

	logic [CMPW-1:0] tgt;
	logic [CMPW-1:0] cnt_w;
	logic [CMPW-1:0] cnt_x;
	logic [FW-1:0]   idx_x;
	logic            last;
	logic            empty;
	logic            full;

	assign cnt_w = CMPW'(cnt_q);
	assign empty = (cnt_q == '0);
	assign full  = (cnt_q == CW'(DEPTH));
	assign last  = (CW'(idx_q) == (cnt_q - CW'(1)));
	assign idx_x = FW'(idx_q);

	always_comb begin
		case (req.action) inside
			ACT_APPEND: tgt = cnt_w;
			ACT_PREPEND: tgt = '0;
			default: tgt = CMPW'(req.position);
		endcase
	end

	always_comb begin
		state_d   = state_q;
		cnt_d     = cnt_q;
		idx_d     = idx_q;
		pos_d     = pos_q;
		val_d     = val_q;
		status_d  = status_q;
		removed_d = removed_q;
		found_d   = found_q;
		mem_we    = 1'b0;
		mem_waddr = idx_q;
		mem_wdata = mem_rdata;
		mem_re    = 1'b0;
		mem_raddr = idx_q;

		unique case (state_q)
			S_IDLE: begin
				if (req_valid) begin
					pos_d     = tgt[AW-1:0];
					val_d     = req.value;
					status_d  = ST_OK;
					removed_d = '0;
					found_d   = '0;
					state_d   = S_DONE;
					case (req.action) inside
						ACT_APPEND, ACT_PREPEND, ACT_INSERT: begin
							if (tgt > cnt_w) begin
								status_d = ST_BADPOS;
							end else if (full) begin
								status_d = ST_FULL;
							end else if (tgt == cnt_w) begin
								// nothing to move: write at the tail directly
								mem_we    = 1'b1;
								mem_waddr = tgt[AW-1:0];
								mem_wdata = req.value;
								cnt_d     = cnt_q + CW'(1);
							end else begin
								mem_re    = 1'b1;
								mem_raddr = AW'(cnt_q - CW'(1));
								idx_d     = AW'(cnt_q - CW'(1));
								state_d   = S_INS;
							end
						end
						ACT_SEARCH: begin
							if (empty) begin
								status_d = ST_NOTFOUND;
							end else begin
								mem_re    = 1'b1;
								mem_raddr = '0;
								idx_d     = '0;
								state_d   = S_SRCH;
							end
						end
						ACT_RM_FRONT: begin
							if (empty) begin
								status_d = ST_EMPTY;
							end else begin
								mem_re    = 1'b1;
								mem_raddr = '0;
								idx_d     = '0;
								state_d   = S_RMF;
							end
						end
						ACT_RM_BACK: begin
							if (empty) begin
								status_d = ST_EMPTY;
							end else begin
								mem_re    = 1'b1;
								mem_raddr = AW'(cnt_q - CW'(1));
								state_d   = S_RMB;
							end
						end
						default: begin
							// unused codes: no operation, status ok
						end
					endcase
				end
			end
			S_INS: begin
				// rdata holds entry idx; it moves to idx+1
				mem_we    = 1'b1;
				mem_waddr = idx_q + AW'(1);
				mem_wdata = mem_rdata;
				if (idx_q == pos_q) begin
					state_d = S_FILL;
				end else begin
					mem_re    = 1'b1;
					mem_raddr = idx_q - AW'(1);
					idx_d     = idx_q - AW'(1);
				end
			end
			S_FILL: begin
				mem_we    = 1'b1;
				mem_waddr = pos_q;
				mem_wdata = val_q;
				cnt_d     = cnt_q + CW'(1);
				state_d   = S_DONE;
			end
			S_SRCH: begin
				if (mem_rdata == val_q) begin
					found_d = idx_x[5:0];
					state_d = S_DONE;
				end else if (last) begin
					status_d = ST_NOTFOUND;
					state_d  = S_DONE;
				end else begin
					mem_re    = 1'b1;
					mem_raddr = idx_q + AW'(1);
					idx_d     = idx_q + AW'(1);
				end
			end
			S_RMF: begin
				if (idx_q == '0) begin
					removed_d = mem_rdata;
				end else begin
					mem_we    = 1'b1;
					mem_waddr = idx_q - AW'(1);
					mem_wdata = mem_rdata;
				end
				if (last) begin
					cnt_d   = cnt_q - CW'(1);
					state_d = S_DONE;
				end else begin
					mem_re    = 1'b1;
					mem_raddr = idx_q + AW'(1);
					idx_d     = idx_q + AW'(1);
				end
			end
			S_RMB: begin
				removed_d = mem_rdata;
				cnt_d     = cnt_q - CW'(1);
				state_d   = S_DONE;
			end
			S_DONE: begin
				if (res_ready) begin
					state_d = S_IDLE;
				end
			end
			default: begin
				state_d = S_IDLE;
			end
		endcase
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q <= S_IDLE;
			cnt_q   <= '0;
		end else begin
			state_q <= state_d;
			cnt_q   <= cnt_d;
		end
	end

	always_ff @(posedge clk) begin
		idx_q     <= idx_d;
		pos_q     <= pos_d;
		val_q     <= val_d;
		status_q  <= status_d;
		removed_q <= removed_d;
		found_q   <= found_d;
	end

	assign req_ready = (state_q == S_IDLE);
	assign res_valid = (state_q == S_DONE);
	assign cnt_x     = CMPW'(cnt_q);

	always_comb begin
		res.status         = status_q;
		res.removed_value  = removed_q;
		res.found_position = found_q;
		res.entry_count    = cnt_x[6:0];
	end

endmodule
